// File: sv/tbrle_pkg.sv
// Shared types, codes and helpers for the two-bit scan-line run-length decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tbrle_pkg;

    // opcodes in bits 3:0 of a command byte
    localparam logic [3:0] OP_EOL        = 4'd0;
    localparam logic [3:0] OP_TEXT       = 4'd1;
    localparam logic [3:0] OP_RUN_0      = 4'd4;
    localparam logic [3:0] OP_RUN_1      = 4'd5;
    localparam logic [3:0] OP_RUN_2      = 4'd6;
    localparam logic [3:0] OP_RUN_3      = 4'd7;
    localparam logic [3:0] OP_RUN_LONG   = 4'd8;
    localparam logic [3:0] OP_RAW_ONE    = 4'd10;
    localparam logic [3:0] OP_RAW_TWO    = 4'd11;
    localparam logic [3:0] OP_RAW_SHORT  = 4'd12;
    localparam logic [3:0] OP_RAW_LONG   = 4'd13;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_BAD_OP   = 2'd2;
    localparam logic [1:0] ST_NO_EOL   = 2'd3;

    // configuration register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;

    localparam logic [15:0] LINE_WIDTH_RESET = 16'd4096;

    // entries between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] pixel;
        logic [9:0] count;
        logic       line_end;
        logic [1:0] status;
    } result_t;

    // all results caused by one code byte, slot 0 first
    typedef struct packed {
        result_t [3:0] slot;
        logic [2:0]    num;
    } entry_t;

    function automatic logic [7:0] level(input logic [1:0] code);
        logic [7:0] lv;
        unique case (code)
            2'd0:    lv = 8'd0;
            2'd1:    lv = 8'd85;
            2'd2:    lv = 8'd170;
            default: lv = 8'd255;
        endcase
        return lv;
    endfunction

    function automatic result_t mk_res(input logic [7:0] pix, input logic [9:0] cnt,
                                       input logic eol, input logic [1:0] st);
        result_t r;
        r.pixel    = pix;
        r.count    = cnt;
        r.line_end = eol;
        r.status   = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/two_bit_scanline_rle_decoder.sv
// Top level of the two-bit scan-line run-length decoder: APB line-width register,
// front parser, entry queue and result back end. Uses tbrle_pkg and the tbrle_* modules.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+----------------------------------
//   s_       | s_valid/s_ready, s_code_byte   | one code byte per transfer
//   m_       | m_valid/m_ready, m_* fields    | one result (pixel, count, flags)
//   apb      | psel/penable/pwrite/paddr/...  | line_width at address 0
//
// The front takes one byte per cycle while the queue has room; the back gives
// one result per cycle while m_ready is high; a byte of raw pixel data, with up to
// four results, sets the sustained rate.
// The first result of a byte passes through its queue entry, then the registered output stage.
// Reset: line width 4096, position zero, parser waits for an opcode.
// A stalled m_ready fills the four-entry queue, then s_ready drops.
`default_nettype none

module two_bit_scanline_rle_decoder
    import tbrle_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_code_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pixel_value,
    output logic [9:0]       m_repeat_count,
    output logic             m_line_end,
    output logic [1:0]       m_status
);

    logic [15:0] line_width_reg;
    logic        s_accept;
    logic        q_push, q_pop, q_full, q_empty;
    entry_t      q_in, q_head;
    result_t     m_result;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_LINE_WIDTH) begin
            line_width_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {16'd0, line_width_reg} : 32'd0;

    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    tbrle_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .code_byte  (s_code_byte),
        .line_width (line_width_reg),
        .push       (q_push),
        .push_entry (q_in)
    );

    tbrle_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    tbrle_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

    assign m_pixel_value  = m_result.pixel;
    assign m_repeat_count = m_result.count;
    assign m_line_end     = m_result.line_end;
    assign m_status       = m_result.status;

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input stalled after reset");

endmodule

`default_nettype wire

// File: sv/tbrle_front.sv
// Front end: parses one accepted code byte per cycle, keeps line position and
// parser state, puts every result of the byte in one queue entry. Uses tbrle_pkg.
`default_nettype none

module tbrle_front
    import tbrle_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  code_byte,
    input  wire logic [15:0] line_width,
    output logic             push,
    output entry_t           push_entry
);

    localparam int SW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

    typedef enum logic [2:0] {
        PH_OPCODE    = 3'd0,
        PH_TEXT_LEN  = 3'd1,
        PH_TEXT_SKIP = 3'd2,
        PH_RUN_LEN   = 3'd3,
        PH_RAW_LEN   = 3'd4,
        PH_RAW_DATA  = 3'd5
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_v;
    logic [1:0]               pend_pix_reg, pend_pix_next;
    logic [3:0]               pend_hi_reg, pend_hi_next;
    logic [11:0]              remain_reg, remain_next;
    logic                     drop_reg, drop_next;

    entry_t          ent;
    logic [3:0]      op;
    logic [SW-1:0]   wid_x;
    logic [SW-1:0]   clip;
    logic [9:0]      run_len;
    logic [11:0]     raw_n;
    logic            do_raw;
    logic [2:0]      cnt;

    assign op    = code_byte[3:0];
    assign wid_x = SW'(line_width);

    always_comb begin
        phase_next    = phase_reg;
        pos_v         = pos_reg;
        pend_pix_next = pend_pix_reg;
        pend_hi_next  = pend_hi_reg;
        remain_next   = remain_reg;
        drop_next     = drop_reg;
        ent           = '0;
        clip          = '0;
        run_len       = '0;
        raw_n         = '0;
        do_raw        = 1'b0;
        cnt           = '0;

        unique case (phase_reg)
            PH_TEXT_LEN: begin
                remain_next = {pend_hi_reg, code_byte};
                phase_next  = (remain_next == '0) ? PH_OPCODE : PH_TEXT_SKIP;
            end
            PH_TEXT_SKIP: begin
                remain_next = remain_reg - 12'd1;
                if (remain_next == '0) begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_RUN_LEN: begin
                phase_next = PH_OPCODE;
                run_len    = {pend_hi_reg[1:0], code_byte};
                if (SW'(pos_v) + SW'(run_len) > wid_x) begin
                    // clip to what is left of the line
                    clip = (SW'(pos_v) < wid_x) ? (wid_x - SW'(pos_v)) : '0;
                    ent.slot[0] = mk_res(level(pend_pix_reg), clip[9:0], 1'b0, ST_DROPPED);
                    ent.num     = 3'd1;
                    if (SW'(pos_v) < wid_x) begin
                        pos_v = wid_x[POSITION_BITS-1:0];
                    end
                end else if (run_len != '0) begin
                    ent.slot[0] = mk_res(level(pend_pix_reg), run_len, 1'b0, ST_OK);
                    ent.num     = 3'd1;
                    pos_v       = pos_v + POSITION_BITS'(run_len);
                end
            end
            PH_RAW_LEN: begin
                raw_n  = {pend_hi_reg, code_byte};
                do_raw = 1'b1;
            end
            PH_RAW_DATA: begin
                cnt = (remain_reg < 12'd4) ? remain_reg[2:0] : 3'd4;
                if (!drop_reg) begin
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < cnt) begin
                            ent.slot[i] = mk_res(level(code_byte[2*i +: 2]), 10'd1, 1'b0,
                                                 ST_OK);
                        end
                    end
                    ent.num = cnt;
                    pos_v   = pos_v + POSITION_BITS'(cnt);
                end
                remain_next = remain_reg - 12'(cnt);
                if (remain_next == '0) begin
                    phase_next = PH_OPCODE;
                end
            end
            default: begin
                phase_next = PH_OPCODE;
                if (op == OP_EOL) begin
                    pos_v       = '0;
                    ent.slot[0] = mk_res(8'd0, 10'd0, 1'b1, ST_OK);
                    ent.num     = 3'd1;
                end else begin
                    // close a full line before decoding the op
                    if (SW'(pos_v) >= wid_x) begin
                        ent.slot[0] = mk_res(8'd0, 10'd0, 1'b1, ST_NO_EOL);
                        ent.num     = 3'd1;
                        pos_v       = '0;
                    end
                    unique case (op)
                        OP_TEXT: begin
                            pend_hi_next = {1'b0, code_byte[7:5]};
                            phase_next   = PH_TEXT_LEN;
                        end
                        OP_RUN_0, OP_RUN_1, OP_RUN_2, OP_RUN_3: begin
                            run_len = 10'(code_byte[7:4]) + 10'd3;
                            if (SW'(pos_v) + SW'(run_len) > wid_x) begin
                                ent.slot[ent.num[1:0]] = mk_res(level(op[1:0]), 10'd0, 1'b0,
                                                                ST_DROPPED);
                            end else begin
                                ent.slot[ent.num[1:0]] = mk_res(level(op[1:0]), run_len, 1'b0,
                                                                ST_OK);
                                pos_v = pos_v + POSITION_BITS'(run_len);
                            end
                            ent.num = ent.num + 3'd1;
                        end
                        OP_RUN_LONG: begin
                            pend_pix_next = code_byte[5:4];
                            pend_hi_next  = {2'b00, code_byte[7:6]};
                            phase_next    = PH_RUN_LEN;
                        end
                        OP_RAW_ONE: begin
                            ent.slot[ent.num[1:0]] = mk_res(level(code_byte[5:4]), 10'd1, 1'b0,
                                                            ST_OK);
                            ent.num = ent.num + 3'd1;
                            pos_v   = pos_v + 1'b1;
                        end
                        OP_RAW_TWO: begin
                            ent.slot[ent.num[1:0]] = mk_res(level(code_byte[5:4]), 10'd1, 1'b0,
                                                            ST_OK);
                            ent.num = ent.num + 3'd1;
                            pos_v   = pos_v + 1'b1;
                            // second pixel only if the line still has room
                            if (SW'(pos_v) < wid_x) begin
                                ent.slot[ent.num[1:0]] = mk_res(level(code_byte[7:6]), 10'd1,
                                                                1'b0, ST_OK);
                                pos_v = pos_v + 1'b1;
                            end else begin
                                ent.slot[ent.num[1:0]] = mk_res(level(code_byte[7:6]), 10'd0,
                                                                1'b0, ST_DROPPED);
                            end
                            ent.num = ent.num + 3'd1;
                        end
                        OP_RAW_SHORT: begin
                            raw_n  = 12'(code_byte[7:4]) + 12'd3;
                            do_raw = 1'b1;
                        end
                        OP_RAW_LONG: begin
                            pend_hi_next = code_byte[7:4];
                            phase_next   = PH_RAW_LEN;
                        end
                        default: begin
                            ent.slot[ent.num[1:0]] = mk_res(8'd0, 10'd0, 1'b0, ST_BAD_OP);
                            ent.num = ent.num + 3'd1;
                        end
                    endcase
                end
            end
        endcase

        // start of a raw string, length known
        if (do_raw) begin
            if (raw_n == '0) begin
                phase_next = PH_OPCODE;
            end else begin
                remain_next = raw_n;
                phase_next  = PH_RAW_DATA;
                if (SW'(pos_v) + SW'(raw_n) > wid_x) begin
                    drop_next = 1'b1;
                    ent.slot[ent.num[1:0]] = mk_res(8'd0, 10'd0, 1'b0, ST_DROPPED);
                    ent.num = ent.num + 3'd1;
                end else begin
                    drop_next = 1'b0;
                end
            end
        end
    end

    assign push       = accept && (ent.num != '0);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_OPCODE;
            pos_reg      <= '0;
            pend_pix_reg <= '0;
            pend_hi_reg  <= '0;
            remain_reg   <= '0;
            drop_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_v;
            pend_pix_reg <= pend_pix_next;
            pend_hi_reg  <= pend_hi_next;
            remain_reg   <= remain_next;
            drop_reg     <= drop_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/tbrle_queue.sv
// Short entry queue between front and back end, depth QUEUE_DEPTH.
// Uses tbrle_pkg for the entry type and depth.
`default_nettype none

module tbrle_queue
    import tbrle_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output logic        full,
    output logic        empty
);

    entry_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + (QPTR_BITS + 1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_BITS + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/tbrle_back.sv
// Back end: walks the slots of the head queue entry and hands out one result per
// cycle while m_ready is high, through a registered output stage. Uses tbrle_pkg.
`default_nettype none

module tbrle_back
    import tbrle_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire entry_t head,
    input  wire logic   empty,
    output logic        pop,
    input  wire logic   m_ready,
    output logic        m_valid,
    output result_t     m_result
);

    logic [1:0] idx_reg;
    logic       m_valid_reg;
    result_t    out_reg;
    logic       out_free;
    logic       load;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = !empty && out_free;
    assign pop      = load && (3'(idx_reg) == head.num - 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= pop ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= head.slot[idx_reg];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire
